@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk with synchronous reset rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/bic_pkg.sv @@
// ---------------------------------------------------------------------------
// bic_pkg
// Types, register codes and helpers of the banked interrupt controller.
// ---------------------------------------------------------------------------
`default_nettype none

package bic_pkg;

  localparam int BANK_W  = 32;
  localparam int BIT_W   = $clog2(BANK_W);
  localparam int BASIC_W = 8;
  localparam int NUM_W   = 7;

  // request opcodes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;

  // register word offsets
  localparam logic [3:0] REG_BASIC_PEND = 4'd0;
  localparam logic [3:0] REG_BANK1_PEND = 4'd1;
  localparam logic [3:0] REG_BANK2_PEND = 4'd2;
  localparam logic [3:0] REG_BANK1_EN   = 4'd4;
  localparam logic [3:0] REG_BANK2_EN   = 4'd5;
  localparam logic [3:0] REG_BASIC_EN   = 4'd6;
  localparam logic [3:0] REG_BANK1_DIS  = 4'd7;
  localparam logic [3:0] REG_BANK2_DIS  = 4'd8;
  localparam logic [3:0] REG_BASIC_DIS  = 4'd9;

  // shortcut sources within each bank
  localparam logic [BANK_W-1:0] SC1_SRC_MASK = 32'h000c_0680; // bits 7,9,10,18,19
  localparam logic [BANK_W-1:0] SC2_SRC_MASK = 32'h43e0_0000; // bits 21-25,30

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         reg_word;
    logic [31:0]        write_data;
    logic [BASIC_W-1:0] src_basic;
    logic [BANK_W-1:0]  src_bank1;
    logic [BANK_W-1:0]  src_bank2;
  } in_req_t;

  typedef struct packed {
    logic               en;
    logic [3:0]         reg_word;
    logic [31:0]        data;
  } wr_req_t;

  typedef struct packed {
    logic [BASIC_W-1:0] basic;
    logic [BANK_W-1:0]  bank1;
    logic [BANK_W-1:0]  bank2;
  } enables_t;

  typedef struct packed {
    logic [31:0]        read_data;
    logic               irq_out;
    logic               active_valid;
    logic [NUM_W-1:0]   active_number;
  } result_t;

  function automatic logic [BIT_W-1:0] low_bit(input logic [BANK_W-1:0] v);
    logic [BIT_W-1:0] res;
    res = '0;
    for (int i = BANK_W - 1; i >= 0; i--) begin
      if (v[i]) res = BIT_W'(i);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bic_if.sv @@
// ---------------------------------------------------------------------------
// bic_if
// Valid/ready channels for requests and results of the interrupt controller.
// ---------------------------------------------------------------------------
`default_nettype none

interface bic_in_if;
  import bic_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [3:0]         reg_word;
  logic [31:0]        write_data;
  logic [BASIC_W-1:0] src_basic;
  logic [BANK_W-1:0]  src_bank1;
  logic [BANK_W-1:0]  src_bank2;

  modport source (output valid, op, reg_word, write_data, src_basic, src_bank1, src_bank2,
                  input ready);
  modport sink (input valid, op, reg_word, write_data, src_basic, src_bank1, src_bank2,
                output ready);
endinterface

interface bic_out_if;
  import bic_pkg::*;
  logic             valid;
  logic             ready;
  logic [31:0]      read_data;
  logic             irq_out;
  logic             active_valid;
  logic [NUM_W-1:0] active_number;

  modport source (output valid, read_data, irq_out, active_valid, active_number,
                  input ready);
  modport sink (input valid, read_data, irq_out, active_valid, active_number,
                output ready);
endinterface

`default_nettype wire

@@ rtl/banked_interrupt_controller_core.sv @@
// ---------------------------------------------------------------------------
// banked_interrupt_controller_core
// Banked level interrupt controller: request register, decode, result register.
// ---------------------------------------------------------------------------
// Two register stages: request register, then result register. Throughput: one
//   request per cycle unless both are full and out_if.ready is low; a new request
//   is taken while a result waits as long as the request register is empty.
// Enable writes commit as the request moves to the result register.
// Reset (rst_n low, synchronous) clears both valid flags and all enables.
`default_nettype none
`include "assert_macros.svh"

module banked_interrupt_controller_core (
  input  wire logic clk,
  input  wire logic rst_n,
  bic_in_if.sink    in_if,
  bic_out_if.source out_if
);
  import bic_pkg::*;

  logic     req_valid_r, res_valid_r;
  in_req_t  req_r, req_nxt;
  result_t  res_r, res_c;
  enables_t en;
  wr_req_t  wr;
  logic     advance, in_fire;

  assign advance     = req_valid_r && (!res_valid_r || out_if.ready);
  assign in_if.ready = !req_valid_r || advance;
  assign in_fire     = in_if.valid && in_if.ready;

  assign req_nxt = '{op: in_if.op, reg_word: in_if.reg_word,
                     write_data: in_if.write_data, src_basic: in_if.src_basic,
                     src_bank1: in_if.src_bank1, src_bank2: in_if.src_bank2};

  assign wr = '{en: advance && (req_r.op == OP_WRITE), reg_word: req_r.reg_word,
                data: req_r.write_data};

  bic_enable_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .en    (en)
  );

  bic_decode u_dec (
    .req (req_r),
    .en  (en),
    .res (res_c)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        req_valid_r <= 1'b1;
      end else if (advance) begin
        req_valid_r <= 1'b0;
      end
      if (advance) begin
        res_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) req_r <= req_nxt;
    if (advance) res_r <= res_c;
  end

  assign out_if.valid         = res_valid_r;
  assign out_if.read_data     = res_r.read_data;
  assign out_if.irq_out       = res_r.irq_out;
  assign out_if.active_valid  = res_r.active_valid;
  assign out_if.active_number = res_r.active_number;

  `ASSERT_IMPL(a_irq_matches_active, out_if.valid, out_if.irq_out == out_if.active_valid)
  `ASSERT_IMPL(a_idle_number_zero, out_if.valid && !out_if.active_valid,
               out_if.active_number == '0)
  `ASSERT_NEXT(a_disable_all_bank1,
               wr.en && (wr.reg_word == REG_BANK1_DIS) && (&wr.data), en.bank1 == '0)
  `ASSERT_IMPL(a_stall_only_when_full, !in_if.ready,
               req_valid_r && res_valid_r && !out_if.ready)

endmodule

`default_nettype wire

@@ rtl/bic_enable_regs.sv @@
// ---------------------------------------------------------------------------
// bic_enable_regs
// Enable state of the three banks, set and clear by write-one requests.
// ---------------------------------------------------------------------------
`default_nettype none

module bic_enable_regs (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bic_pkg::wr_req_t  wr,
  output      bic_pkg::enables_t en
);
  import bic_pkg::*;

  enables_t en_r, en_nxt;

  always_comb begin
    en_nxt = en_r;
    if (wr.en) begin
      case (wr.reg_word)
        REG_BANK1_EN:  en_nxt.bank1 = en_r.bank1 | wr.data;
        REG_BANK2_EN:  en_nxt.bank2 = en_r.bank2 | wr.data;
        REG_BASIC_EN:  en_nxt.basic = en_r.basic | wr.data[BASIC_W-1:0];
        REG_BANK1_DIS: en_nxt.bank1 = en_r.bank1 & ~wr.data;
        REG_BANK2_DIS: en_nxt.bank2 = en_r.bank2 & ~wr.data;
        REG_BASIC_DIS: en_nxt.basic = en_r.basic & ~wr.data[BASIC_W-1:0];
        default:       en_nxt = en_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= '0;
    end else begin
      en_r <= en_nxt;
    end
  end

  assign en = en_r;

endmodule

`default_nettype wire

@@ rtl/bic_decode.sv @@
// ---------------------------------------------------------------------------
// bic_decode
// Pending words, shortcut mapping, active interrupt decode and read mux.
// ---------------------------------------------------------------------------
`default_nettype none

module bic_decode (
  input  wire bic_pkg::in_req_t  req,
  input  wire bic_pkg::enables_t en,
  output      bic_pkg::result_t  res
);
  import bic_pkg::*;

  logic [BASIC_W-1:0] p0;
  logic [BANK_W-1:0]  p1, p2, rest1, rest2, sc1_w, sc2_w;
  logic [4:0]         sc1;
  logic [5:0]         sc2;
  logic [31:0]        basic;
  logic [BIT_W-1:0]   p0_low;
  logic [NUM_W-1:0]   num;

  assign p0    = req.src_basic & en.basic;
  assign p1    = req.src_bank1 & en.bank1;
  assign p2    = req.src_bank2 & en.bank2;
  assign sc1_w = p1 & SC1_SRC_MASK;
  assign sc2_w = p2 & SC2_SRC_MASK;
  assign rest1 = p1 & ~SC1_SRC_MASK;
  assign rest2 = p2 & ~SC2_SRC_MASK;
  assign sc1   = {p1[19], p1[18], p1[10], p1[9], p1[7]};
  assign sc2   = {p2[30], p2[25], p2[24], p2[23], p2[22], p2[21]};
  assign basic = {11'd0, sc2, sc1, |rest2, |rest1, p0};

  assign p0_low = low_bit({(BANK_W-BASIC_W)'(0), p0});

  // shortcuts map to their bank bits in ascending order, so the lowest
  // masked bank bit is the lowest shortcut
  always_comb begin
    num = '0;
    if (|p0) begin
      num = {2'd0, p0_low};
    end else if (|sc1) begin
      num = {2'd1, low_bit(sc1_w)};
    end else if (|sc2) begin
      num = {2'd2, low_bit(sc2_w)};
    end else if (|rest1) begin
      num = {2'd1, low_bit(p1)};
    end else if (|rest2) begin
      num = {2'd2, low_bit(p2)};
    end
  end

  always_comb begin
    res.read_data = '0;
    if (req.op == OP_READ) begin
      case (req.reg_word)
        REG_BASIC_PEND: res.read_data = basic;
        REG_BANK1_PEND: res.read_data = p1;
        REG_BANK2_PEND: res.read_data = p2;
        REG_BANK1_EN:   res.read_data = en.bank1;
        REG_BANK2_EN:   res.read_data = en.bank2;
        REG_BASIC_EN:   res.read_data = {(32-BASIC_W)'(0), en.basic};
        default:        res.read_data = '0;
      endcase
    end
    res.irq_out       = (|p0) | (|p1) | (|p2);
    res.active_valid  = |basic;
    res.active_number = num;
  end

endmodule

`default_nettype wire
